// ----- src/csv_field_splitter_core_assert.svh -----
// Assertion macros shared by the splitter modules.
`ifndef CSV_FIELD_SPLITTER_CORE_ASSERT_SVH
`define CSV_FIELD_SPLITTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSV_FS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("splitter assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define CSV_FS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("splitter assertion failed");

`endif

// ----- src/csv_fs_pkg.sv -----
`timescale 1ns / 1ps

package csv_fs_pkg;

	localparam int WS_HOLD_DEPTH_DEF = 16;
	localparam int HOLD_DEPTH_MAX    = 256;
	localparam int HOLD_IDX_MAX_W    = 8;
	localparam int HOLD_CNT_MAX_W    = 9;
	localparam int QUEUE_DEPTH       = 4;

	localparam logic [7:0] QUOTE_CHAR  = 8'h22;
	localparam logic [7:0] SPACE_CHAR  = 8'h20;
	localparam logic [7:0] DELIM_RESET = 8'h2C;

	// Result phases of one command, emitted from the lowest bit up.
	localparam int PH_PRE   = 0;
	localparam int PH_FLUSH = 1;
	localparam int PH_BYTE  = 2;
	localparam int PH_MARK  = 3;
	localparam int PH_LINE  = 4;
	localparam int NUM_PH   = 5;

	typedef struct packed {
		logic                      hold_we;
		logic [HOLD_IDX_MAX_W-1:0] hold_idx;
		logic [7:0]                data;
		logic                      pre;
		logic [HOLD_CNT_MAX_W-1:0] flush_n;
		logic                      drop;
		logic                      emit_byte;
		logic                      mark;
		logic                      line;
		logic                      line_endf;
	} cmd_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == SPACE_CHAR) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

endpackage

// ----- src/csv_fs_front.sv -----
`timescale 1ns / 1ps

module csv_fs_front #(
	parameter int WS_HOLD_DEPTH = csv_fs_pkg::WS_HOLD_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              byte_present,
	input  logic              line_last,
	input  logic [7:0]        delimiter,
	input  logic              q_full,
	output logic              push,
	output csv_fs_pkg::cmd_t  cmd
);

	localparam int CNT_W = $clog2(WS_HOLD_DEPTH + 1);
	localparam int IDX_W = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;

	logic             quoting_q, qseen_q, started_q, ovf_q;
	logic [CNT_W-1:0] hcnt_q;

	logic             quoting_d, qseen_d, started_d, ovf_d;
	logic [CNT_W-1:0] hcnt_d;
	logic             accept, tok_mode, handled, any_res;
	csv_fs_pkg::cmd_t cmd_c;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign tok_mode = (delimiter == csv_fs_pkg::SPACE_CHAR);

	always_comb begin
		quoting_d = quoting_q;
		qseen_d   = qseen_q;
		started_d = started_q;
		ovf_d     = ovf_q;
		hcnt_d    = hcnt_q;
		handled   = 1'b0;
		cmd_c     = '0;
		cmd_c.data = in_byte;

		if (byte_present) begin
			if (tok_mode) begin
				if (csv_fs_pkg::is_ws(in_byte)) begin
					// The separator is kept so a later field end can be emitted.
					if (started_q && hcnt_q == '0) begin
						cmd_c.hold_we  = 1'b1;
						cmd_c.hold_idx = '0;
						hcnt_d         = CNT_W'(1);
					end
				end else begin
					cmd_c.pre       = started_q && (hcnt_q != '0);
					cmd_c.emit_byte = 1'b1;
					started_d       = 1'b1;
					hcnt_d          = '0;
					ovf_d           = 1'b0;
				end
			end else begin
				if (qseen_q) begin
					qseen_d = 1'b0;
					if (in_byte != csv_fs_pkg::QUOTE_CHAR) begin
						quoting_d = 1'b0;
					end
				end
				// A doubled quote inside quotes falls through as content.
				if (!(qseen_q && in_byte == csv_fs_pkg::QUOTE_CHAR)) begin
					if (in_byte == csv_fs_pkg::QUOTE_CHAR) begin
						handled = 1'b1;
						if (quoting_d) begin
							qseen_d = 1'b1;
						end else begin
							quoting_d = 1'b1;
						end
					end else if (in_byte == delimiter && !quoting_d) begin
						handled    = 1'b1;
						cmd_c.mark = 1'b1;
						started_d  = 1'b0;
						hcnt_d     = '0;
						ovf_d      = 1'b0;
					end
				end
				if (!handled) begin
					if (csv_fs_pkg::is_ws(in_byte)) begin
						if (started_q) begin
							if (hcnt_q < CNT_W'(WS_HOLD_DEPTH)) begin
								cmd_c.hold_we  = 1'b1;
								cmd_c.hold_idx = csv_fs_pkg::HOLD_IDX_MAX_W'(hcnt_q[IDX_W-1:0]);
								hcnt_d         = hcnt_q + 1'b1;
							end else begin
								ovf_d = 1'b1;
							end
						end
					end else begin
						cmd_c.flush_n   = csv_fs_pkg::HOLD_CNT_MAX_W'(hcnt_q);
						cmd_c.drop      = ovf_q;
						cmd_c.emit_byte = 1'b1;
						started_d       = 1'b1;
						hcnt_d          = '0;
						ovf_d           = 1'b0;
					end
				end
			end
		end

		if (line_last) begin
			// Held bytes die with the line, so no write is needed.
			cmd_c.hold_we   = 1'b0;
			cmd_c.line      = 1'b1;
			cmd_c.line_endf = tok_mode ? started_d : 1'b1;
			quoting_d       = 1'b0;
			qseen_d         = 1'b0;
			started_d       = 1'b0;
			hcnt_d          = '0;
			ovf_d           = 1'b0;
		end
	end

	assign any_res = cmd_c.pre || cmd_c.emit_byte || cmd_c.mark || cmd_c.line;
	assign push    = accept && (cmd_c.hold_we || any_res);
	assign cmd     = cmd_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quoting_q <= 1'b0;
			qseen_q   <= 1'b0;
			started_q <= 1'b0;
			ovf_q     <= 1'b0;
			hcnt_q    <= '0;
		end else if (accept) begin
			quoting_q <= quoting_d;
			qseen_q   <= qseen_d;
			started_q <= started_d;
			ovf_q     <= ovf_d;
			hcnt_q    <= hcnt_d;
		end
	end

endmodule

// ----- src/csv_fs_queue.sv -----
`timescale 1ns / 1ps

`include "csv_field_splitter_core_assert.svh"

module csv_fs_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  csv_fs_pkg::cmd_t push_cmd,
	input  logic             pop,
	output logic             full,
	output logic             head_valid,
	output csv_fs_pkg::cmd_t head_cmd
);

	localparam int DEPTH = csv_fs_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	csv_fs_pkg::cmd_t   slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`CSV_FS_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !full)
	`CSV_FS_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, head_valid)
	`CSV_FS_ASSERT_NEXT(a_fills_up, clk, arst_n, push && !pop && count_q == CNT_W'(DEPTH - 1), full)

endmodule

// ----- src/csv_fs_back.sv -----
`timescale 1ns / 1ps

`include "csv_field_splitter_core_assert.svh"

module csv_fs_back #(
	parameter int WS_HOLD_DEPTH = csv_fs_pkg::WS_HOLD_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  csv_fs_pkg::cmd_t head_cmd,
	output logic             pop,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,  // [7:0] out_byte
	output logic [3:0]       m_tuser,  // [0] has_byte, [1] ends_field, [2] ends_line,
	                                   // [3] ws_dropped
	output logic             m_tlast   // last_of_run
);

	localparam int CNT_W = $clog2(WS_HOLD_DEPTH + 1);
	localparam int IDX_W = (WS_HOLD_DEPTH > 1) ? $clog2(WS_HOLD_DEPTH) : 1;
	localparam int NPH   = csv_fs_pkg::NUM_PH;

	logic [7:0]       hold_mem [WS_HOLD_DEPTH];
	logic [7:0]       rd_q;

	logic             loaded_q;
	logic [NPH-1:0]   pend_q;
	logic [IDX_W-1:0] idx_q;

	logic             valid_s2, has_s2, mem_s2, endf_s2, endl_s2, drop_s2, last_s2;
	logic [7:0]       byte_s2;

	logic             is_hold, can_adv, emit, last_flush, last_res;
	logic [NPH-1:0]   head_pend, eff_pend, cur, new_pend;
	logic [IDX_W-1:0] eff_idx;
	logic [CNT_W-1:0] flush_n, idx_ext;

	assign flush_n   = head_cmd.flush_n[CNT_W-1:0];
	assign head_pend = {head_cmd.line, head_cmd.mark, head_cmd.emit_byte,
		(flush_n != '0), head_cmd.pre};
	assign eff_pend  = loaded_q ? pend_q : head_pend;
	assign eff_idx   = loaded_q ? idx_q : '0;
	assign idx_ext   = CNT_W'(eff_idx);
	assign cur       = eff_pend & (~eff_pend + 1'b1);

	assign is_hold = head_valid && head_cmd.hold_we;
	assign can_adv = !valid_s2 || m_tready;
	assign emit    = head_valid && !head_cmd.hold_we && can_adv;

	// The flush phase stays pending until its last held byte has been read.
	assign last_flush = ((idx_ext + 1'b1) == flush_n);
	always_comb begin
		new_pend = eff_pend & ~cur;
		if (cur[csv_fs_pkg::PH_FLUSH] && !last_flush) begin
			new_pend[csv_fs_pkg::PH_FLUSH] = 1'b1;
		end
	end
	assign last_res = (new_pend == '0);
	assign pop      = is_hold || (emit && last_res);

	always_ff @(posedge clk) begin
		if (is_hold) begin
			hold_mem[head_cmd.hold_idx[IDX_W-1:0]] <= head_cmd.data;
		end
		if (emit && cur[csv_fs_pkg::PH_FLUSH]) begin
			rd_q <= hold_mem[eff_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			pend_q   <= '0;
			idx_q    <= '0;
		end else if (emit) begin
			loaded_q <= !last_res;
			pend_q   <= new_pend;
			if (cur[csv_fs_pkg::PH_FLUSH] && !last_flush) begin
				idx_q <= eff_idx + 1'b1;
			end else begin
				idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_adv) begin
			valid_s2 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			has_s2  <= cur[csv_fs_pkg::PH_FLUSH] || cur[csv_fs_pkg::PH_BYTE];
			mem_s2  <= cur[csv_fs_pkg::PH_FLUSH];
			byte_s2 <= head_cmd.data;
			endf_s2 <= cur[csv_fs_pkg::PH_PRE] || cur[csv_fs_pkg::PH_MARK] ||
				(cur[csv_fs_pkg::PH_LINE] && head_cmd.line_endf);
			endl_s2 <= cur[csv_fs_pkg::PH_LINE];
			drop_s2 <= (cur[csv_fs_pkg::PH_FLUSH] || cur[csv_fs_pkg::PH_BYTE]) && head_cmd.drop;
			last_s2 <= last_res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = has_s2 ? (mem_s2 ? rd_q : byte_s2) : 8'h00;
	assign m_tuser  = {drop_s2, endl_s2, endf_s2, has_s2};
	assign m_tlast  = last_s2;

	`CSV_FS_ASSERT_NOW(a_one_phase, clk, arst_n, emit, $onehot(cur))
	`CSV_FS_ASSERT_NOW(a_partial_at_head, clk, arst_n, loaded_q, head_valid && !head_cmd.hold_we)
	`CSV_FS_ASSERT_NEXT(a_last_clears, clk, arst_n, emit && last_res, !loaded_q)

endmodule

// ----- src/csv_field_splitter_core.sv -----
`timescale 1ns / 1ps

// Field splitter for text lines. Bytes of a line enter on the s_ channel one
// word at a time; s_tuser flags a present byte and s_tlast marks the line end.
// Each field byte, field end and line end leaves on the m_ channel as one word;
// m_tlast marks the last word caused by one input word.
// The user must write the delimiter on the cfg_ channel only while the block
// is idle; the block does not enforce it. The value 0x20 selects whitespace
// token mode, where quotes are ordinary bytes. The front classifies one input
// word per cycle while the queue has room, queuing a command if needed. The
// back emits one output word per cycle while the receiver is ready. In
// delimiter mode, trailing whitespace held in the hold memory (one read
// port) is flushed one byte a cycle ahead of the next content byte, up to
// WS_HOLD_DEPTH + 2 words. Words go from the queue via the output register.
// If the receiver stalls, the output register holds its word, the queue of
// four commands fills, and s_tready drops once it is full.
// Reset clears the line state, empties the queue and sets the delimiter to
// a comma; the hold memory needs no clearing.
module csv_field_splitter_core #(
	parameter int WS_HOLD_DEPTH = csv_fs_pkg::WS_HOLD_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tuser,   // [0] byte_present
	input  logic       s_tlast,   // line_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [3:0] m_tuser,   // [0] has_byte, [1] ends_field, [2] ends_line,
	                              // [3] ws_dropped
	output logic       m_tlast,   // last_of_run
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data   // [7:0] field_delimiter
);

	logic [7:0]       delim_q;
	logic             push, pop, full, head_valid;
	csv_fs_pkg::cmd_t push_cmd, head_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= csv_fs_pkg::DELIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			delim_q <= cfg_data;
		end
	end

	csv_fs_front #(
		.WS_HOLD_DEPTH(WS_HOLD_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_byte      (s_tdata),
		.byte_present (s_tuser),
		.line_last    (s_tlast),
		.delimiter    (delim_q),
		.q_full       (full),
		.push         (push),
		.cmd          (push_cmd)
	);

	csv_fs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	csv_fs_back #(
		.WS_HOLD_DEPTH(WS_HOLD_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule
